// ===== rtl/pfte_pkg.sv =====
// ----------------------------------------------------------------------------
// pfte_pkg
// Shared types, codes and sizing constants of the prime factor table engine.
// ----------------------------------------------------------------------------
package pfte_pkg;

  // default sizing
  localparam int TABLE_DEPTH = 4096;
  localparam int VALUE_WIDTH = 32;

  // limit register
  localparam int         LIMIT_W     = 12;
  localparam logic [11:0] LIMIT_RESET = 12'd4095;

  // factor stack of the table path
  localparam int MAX_RES = 32;
  localparam int SP_W    = $clog2(MAX_RES + 1);
  localparam int SI_W    = $clog2(MAX_RES);

  // result status codes
  localparam logic [1:0] ST_FACTOR = 2'd0;
  localparam logic [1:0] ST_BUILT  = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  // request action codes
  localparam logic ACT_BUILD  = 1'b0;
  localparam logic ACT_FACTOR = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] factor;
    logic [1:0]  status;
    logic        last;
  } res_t;

  // source of an emitted result
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_BUILT,
    SRC_PEND,
    SRC_X,
    SRC_STACK
  } src_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr_step;
    logic scan_init;
    logic rd_scan;
    logic i_inc;
    logic mark_init;
    logic mark_step;
    logic set_built;
    logic div_trial;
    logic trial_hit;
    logic trial_miss;
    logic pend_set_x;
    logic rd_tab;
    logic push_tab;
    logic tab_quot;
    logic pop;
    logic emit;
    src_t emit_sel;
    logic emit_last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic act_factor;
    logic v_zero;
    logic v_one;
    logic tab_path;
    logic clr_last;
    logic i_gt_l;
    logic rd_zero;
    logic j_gt_l;
    logic sq_gt_x;
    logic div_done;
    logic rem_zero;
    logic pend_valid;
    logic x_gt1;
    logic sp_full;
    logic sp_one;
  } stat_t;

endpackage

// ===== rtl/pfte_ram.sv =====
// ----------------------------------------------------------------------------
// pfte_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pfte_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pfte_div.sv =====
// ----------------------------------------------------------------------------
// pfte_div
// Restoring divider, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module pfte_div #(
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [VW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] quot,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(VW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;

  assign trial = {rem, quot[VW-1]};

  // control: count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(VW);
      end else if (run) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // datapath: shift, compare, subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (run) begin
      if (trial >= {1'b0, dvs}) begin
        rem  <= VW'(trial - {1'b0, dvs});
        quot <= {quot[VW-2:0], 1'b1};
      end else begin
        rem  <= trial[VW-1:0];
        quot <= {quot[VW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/pfte_datapath.sv =====
// ----------------------------------------------------------------------------
// pfte_datapath
// Limit register, factor table, divider, trial and table walk registers,
// factor stack and result register.
// ----------------------------------------------------------------------------
module pfte_datapath #(
  parameter int DEPTH = pfte_pkg::TABLE_DEPTH,
  parameter int VW    = pfte_pkg::VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pfte_pkg::req_t                      req,
  input  logic                                cfg_we,
  input  logic [pfte_pkg::LIMIT_W-1:0]        cfg_data,
  input  pfte_pkg::cmd_t                      cmd,
  output pfte_pkg::stat_t                     stat,
  output logic                                strobe,
  output pfte_pkg::res_t                      res
);

  localparam int IW  = $clog2(DEPTH);
  localparam int AW  = IW + 1;
  localparam int DW  = VW / 2 + 1;
  localparam int SQW = VW + 2;

  logic [pfte_pkg::LIMIT_W-1:0] limit;
  logic                         built;
  logic [IW-1:0]                eff;
  logic [VW-1:0]                v;
  logic [VW-1:0]                x;
  logic [DW-1:0]                d;
  logic [SQW-1:0]               sq;
  logic [AW-1:0]                i;
  logic [AW-1:0]                j;
  logic [VW-1:0]                pend;
  logic                         pend_valid;
  logic [IW-1:0]                stack [pfte_pkg::MAX_RES];
  logic [pfte_pkg::SP_W-1:0]    sp;
  logic [pfte_pkg::SI_W-1:0]    top_idx;
  logic [IW-1:0]                rdata;
  logic [IW-1:0]                p;
  logic                         ram_we;
  logic [IW-1:0]                waddr;
  logic [IW-1:0]                wdata;
  logic [IW-1:0]                raddr;
  logic                         div_start;
  logic [VW-1:0]                div_dvs;
  logic                         div_done;
  logic [VW-1:0]                quot;
  logic [VW-1:0]                rem;

  // effective limit, clamped to the table
  always_comb begin
    if (32'(limit) > 32'(DEPTH - 1)) begin
      eff = IW'(DEPTH - 1);
    end else begin
      eff = IW'(limit);
    end
  end

  assign v       = req.value[VW-1:0];
  assign top_idx = pfte_pkg::SI_W'(sp - pfte_pkg::SP_W'(1));

  // table entry with the guard for entries that cannot split the value
  always_comb begin
    if (rdata < IW'(2) || 32'(rdata) > 32'(x)) begin
      p = IW'(x);
    end else begin
      p = rdata;
    end
  end

  // status to the controller
  always_comb begin
    stat.act_factor = (req.action == pfte_pkg::ACT_FACTOR);
    stat.v_zero     = (v == '0);
    stat.v_one      = (v == VW'(1));
    stat.tab_path   = built && (32'(v) <= 32'(eff));
    stat.clr_last   = (i == AW'(eff));
    stat.i_gt_l     = (i > AW'(eff));
    stat.rd_zero    = (rdata == '0);
    stat.j_gt_l     = (j > AW'(eff));
    stat.sq_gt_x    = (sq > SQW'(x));
    stat.div_done   = div_done;
    stat.rem_zero   = (rem == '0);
    stat.pend_valid = pend_valid;
    stat.x_gt1      = (x > VW'(1));
    stat.sp_full    = (sp == pfte_pkg::SP_W'(pfte_pkg::MAX_RES));
    stat.sp_one     = (sp == pfte_pkg::SP_W'(1));
  end

  // configuration and built mark
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= pfte_pkg::LIMIT_RESET;
      built <= 1'b0;
    end else if (cfg_we) begin
      limit <= cfg_data;
      built <= 1'b0;
    end else if (cmd.set_built) begin
      built <= 1'b1;
    end
  end

  // factor table
  assign ram_we = cmd.clr_step || cmd.mark_step;
  assign waddr  = cmd.clr_step ? IW'(i) : IW'(j);
  assign wdata  = cmd.clr_step ? '0 : IW'(i);
  assign raddr  = cmd.rd_scan ? IW'(i) : IW'(x);

  pfte_ram #(
    .WIDTH (IW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared divider
  assign div_start = cmd.div_trial || cmd.push_tab;
  assign div_dvs   = cmd.push_tab ? VW'(p) : VW'(d);

  pfte_div #(
    .VW (VW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (x),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // sieve indexes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      i <= '0;
    end else if (cmd.scan_init) begin
      i <= AW'(2);
    end else if (cmd.clr_step || cmd.i_inc) begin
      i <= i + AW'(1);
    end
    if (cmd.mark_init) begin
      j <= i;
    end else if (cmd.mark_step) begin
      j <= j + i;
    end
  end

  // remaining value, trial divisor and its square
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x  <= v;
      d  <= DW'(2);
      sq <= SQW'(4);
    end else if (cmd.trial_hit || cmd.tab_quot) begin
      x <= quot;
    end else if (cmd.trial_miss) begin
      d  <= d + DW'(1);
      sq <= sq + SQW'({d, 1'b1});
    end
  end

  // pending trial factor, held until the next one shows whether it is last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.load) begin
      pend_valid <= 1'b0;
    end else if (cmd.trial_hit || cmd.pend_set_x) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.trial_hit) begin
      pend <= VW'(d);
    end else if (cmd.pend_set_x) begin
      pend <= x;
    end
  end

  // factor stack: largest first in, smallest first out
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.load) begin
      sp <= '0;
    end else if (cmd.push_tab) begin
      sp <= sp + pfte_pkg::SP_W'(1);
    end else if (cmd.pop) begin
      sp <= sp - pfte_pkg::SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_tab) begin
      stack[pfte_pkg::SI_W'(sp)] <= p;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.last <= cmd.emit_last;
      case (cmd.emit_sel)
        pfte_pkg::SRC_ZERO: begin
          res.factor <= '0;
          res.status <= pfte_pkg::ST_NONE;
        end
        pfte_pkg::SRC_ONE: begin
          res.factor <= 32'd1;
          res.status <= pfte_pkg::ST_FACTOR;
        end
        pfte_pkg::SRC_BUILT: begin
          res.factor <= '0;
          res.status <= pfte_pkg::ST_BUILT;
        end
        pfte_pkg::SRC_PEND: begin
          res.factor <= 32'(pend);
          res.status <= pfte_pkg::ST_FACTOR;
        end
        pfte_pkg::SRC_X: begin
          res.factor <= 32'(x);
          res.status <= pfte_pkg::ST_FACTOR;
        end
        pfte_pkg::SRC_STACK: begin
          res.factor <= 32'(stack[top_idx]);
          res.status <= pfte_pkg::ST_FACTOR;
        end
        default: begin
          res.factor <= '0;
          res.status <= pfte_pkg::ST_FACTOR;
        end
      endcase
    end
  end

endmodule

// ===== rtl/pfte_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfte_ctrl
// Sequencer for table build, trial division and table walk.
// ----------------------------------------------------------------------------
module pfte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pfte_pkg::stat_t stat,
  output pfte_pkg::cmd_t  cmd,
  output logic            busy
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLR   = 14'b00000000000010,
    S_SRD   = 14'b00000000000100,
    S_SCHK  = 14'b00000000001000,
    S_MARK  = 14'b00000000010000,
    S_BDONE = 14'b00000000100000,
    S_TTEST = 14'b00000001000000,
    S_TDIV  = 14'b00000010000000,
    S_TEND  = 14'b00000100000000,
    S_TLAST = 14'b00001000000000,
    S_TRD   = 14'b00010000000000,
    S_TCHK  = 14'b00100000000000,
    S_TDIVW = 14'b01000000000000,
    S_TPOP  = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit_sel = pfte_pkg::SRC_ZERO;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (!stat.act_factor) begin
            state_next = S_CLR;
          end else if (stat.v_zero) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = pfte_pkg::SRC_ZERO;
            cmd.emit_last = 1'b1;
          end else if (stat.tab_path) begin
            if (stat.v_one) begin
              cmd.emit      = 1'b1;
              cmd.emit_sel  = pfte_pkg::SRC_ONE;
              cmd.emit_last = 1'b1;
            end else begin
              state_next = S_TRD;
            end
          end else begin
            state_next = S_TTEST;
          end
        end
      end
      // clear entries 0..limit
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SRD;
        end
      end
      S_SRD: begin
        if (stat.i_gt_l) begin
          state_next = S_BDONE;
        end else begin
          cmd.rd_scan = 1'b1;
          state_next  = S_SCHK;
        end
      end
      // untouched entry: a prime, mark its multiples
      S_SCHK: begin
        if (stat.rd_zero) begin
          cmd.mark_init = 1'b1;
          state_next    = S_MARK;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_SRD;
        end
      end
      S_MARK: begin
        if (stat.j_gt_l) begin
          cmd.i_inc  = 1'b1;
          state_next = S_SRD;
        end else begin
          cmd.mark_step = 1'b1;
        end
      end
      S_BDONE: begin
        cmd.set_built = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_sel  = pfte_pkg::SRC_BUILT;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      // trial division while d*d <= x
      S_TTEST: begin
        if (stat.sq_gt_x) begin
          state_next = S_TEND;
        end else begin
          cmd.div_trial = 1'b1;
          state_next    = S_TDIV;
        end
      end
      S_TDIV: begin
        if (stat.div_done) begin
          if (stat.rem_zero) begin
            cmd.trial_hit = 1'b1;
            if (stat.pend_valid) begin
              cmd.emit     = 1'b1;
              cmd.emit_sel = pfte_pkg::SRC_PEND;
            end
          end else begin
            cmd.trial_miss = 1'b1;
          end
          state_next = S_TTEST;
        end
      end
      // flush the pending factor and the leftover prime
      S_TEND: begin
        state_next = S_IDLE;
        if (stat.x_gt1) begin
          cmd.emit = 1'b1;
          if (stat.pend_valid) begin
            cmd.emit_sel   = pfte_pkg::SRC_PEND;
            cmd.pend_set_x = 1'b1;
            state_next     = S_TLAST;
          end else begin
            cmd.emit_sel  = pfte_pkg::SRC_X;
            cmd.emit_last = 1'b1;
          end
        end else if (stat.pend_valid) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = pfte_pkg::SRC_PEND;
          cmd.emit_last = 1'b1;
        end
      end
      S_TLAST: begin
        cmd.emit      = 1'b1;
        cmd.emit_sel  = pfte_pkg::SRC_PEND;
        cmd.emit_last = 1'b1;
        state_next    = S_IDLE;
      end
      // table walk: read largest factor, push it, divide it out
      S_TRD: begin
        if (!stat.x_gt1 || stat.sp_full) begin
          state_next = S_TPOP;
        end else begin
          cmd.rd_tab = 1'b1;
          state_next = S_TCHK;
        end
      end
      S_TCHK: begin
        cmd.push_tab = 1'b1;
        state_next   = S_TDIVW;
      end
      S_TDIVW: begin
        if (stat.div_done) begin
          cmd.tab_quot = 1'b1;
          state_next   = S_TRD;
        end
      end
      // drain the stack smallest first
      S_TPOP: begin
        cmd.pop       = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_sel  = pfte_pkg::SRC_STACK;
        cmd.emit_last = stat.sp_one;
        if (stat.sp_one) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/prime_factor_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// prime_factor_table_engine_unit
// Sieve table build and prime factorization by table walk or trial division.
// ----------------------------------------------------------------------------
// Build: clear entries 0..L, then scan each entry and mark the multiples
//   of each prime found (L = limit, clamped to the table), then one result.
// Factorize 0, or 1 on the table path: result in the cycle after start.
// Trial path: one divider run per candidate divisor up to the square root
//   of the remaining value; table path: one divider run per factor.
// One item at a time; results cannot be stalled.
// Reset (rst, synchronous) sets limit 4095, clears the built mark; table
//   contents stay undefined until a build.
module prime_factor_table_engine_unit #(
  parameter int TABLE_DEPTH = pfte_pkg::TABLE_DEPTH,
  parameter int VALUE_WIDTH = pfte_pkg::VALUE_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  pfte_pkg::req_t               req,
  input  logic                         cfg_we,
  input  logic [pfte_pkg::LIMIT_W-1:0] cfg_data,
  output logic                         strobe,
  output pfte_pkg::res_t               res
);

  pfte_pkg::cmd_t  cmd;
  pfte_pkg::stat_t stat;

  pfte_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  pfte_datapath #(
    .DEPTH (TABLE_DEPTH),
    .VW    (VALUE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .strobe   (strobe),
    .res      (res)
  );

endmodule
